// File: sv/jca_pkg.sv
// shared constants, register codes and pipeline types for the coefficient address map
`timescale 1ns / 1ps

package jca_pkg;

  localparam int NUM_SLOTS       = 4;
  localparam int MAX_COMPONENTS  = 4;
  // coefficients per block must stay a power of two: the coefficient position is a bit slice
  localparam int COEFS_PER_BLOCK = 64;
  localparam int BLOCK_LOG2      = $clog2(COEFS_PER_BLOCK);

  localparam int IDX_W           = 32;
  localparam int REG_W           = 14;
  localparam int CFG_IDX_W       = 3;
  localparam int CNT_W           = 2 * REG_W;
  localparam int CUM_W           = CNT_W + $clog2(NUM_SLOTS);
  localparam int BLK_W           = IDX_W - BLOCK_LOG2;
  localparam int TOTAL_W         = 35;
  localparam int TOTAL_FULL_W    = CUM_W + BLOCK_LOG2;
  localparam int COMP_W          = 2;
  localparam int ROW_W           = 13;
  localparam int COL_W           = 13;
  localparam int POS_W           = BLOCK_LOG2;

  // quotient (block row) is always below the height, so it fits in a register width
  localparam int QUO_W           = REG_W;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_0,
    REG_HEIGHT_0,
    REG_WIDTH_1,
    REG_HEIGHT_1,
    REG_WIDTH_2,
    REG_HEIGHT_2,
    REG_WIDTH_3,
    REG_HEIGHT_3
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_SLOTS-1:0][CUM_W-1:0] cum;
    logic [NUM_SLOTS-1:0][REG_W-1:0] width;
    logic [TOTAL_W-1:0]              total;
    logic                            settle;
  } cfg_view_t;

  typedef struct packed {
    logic [COMP_W-1:0] comp;
    logic              oor;
    logic [POS_W-1:0]  pos;
    logic [REG_W-1:0]  divisor;
    logic [REG_W-1:0]  rem;
    logic [QUO_W-1:0]  dvd;
    logic [QUO_W-1:0]  quo;
  } div_item_t;

endpackage

// File: sv/jca_cfg_regs.sv
// configuration registers with registered per-component block counts and running sums
`timescale 1ns / 1ps

module jca_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [jca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jca_pkg::REG_W-1:0]        cfg_data,
  output jca_pkg::cfg_view_t               view
);

  logic [jca_pkg::NUM_SLOTS-1:0][jca_pkg::REG_W-1:0] width_r;
  logic [jca_pkg::NUM_SLOTS-1:0][jca_pkg::REG_W-1:0] height_r;
  logic [jca_pkg::NUM_SLOTS-1:0][jca_pkg::CNT_W-1:0] cnt_r;
  logic [jca_pkg::NUM_SLOTS-1:0][jca_pkg::CNT_W-1:0] cnt_nxt;
  logic [jca_pkg::NUM_SLOTS-1:0][jca_pkg::CUM_W-1:0] cum_r;
  logic [jca_pkg::NUM_SLOTS-1:0][jca_pkg::CUM_W-1:0] cum_nxt;
  logic [jca_pkg::TOTAL_W-1:0]                       total_r;
  logic [jca_pkg::TOTAL_W-1:0]                       total_nxt;
  logic                                              settle_r;
  logic [jca_pkg::CUM_W-1:0]                         pair01;
  logic [jca_pkg::CUM_W-1:0]                         pair23;
  logic [jca_pkg::TOTAL_FULL_W-1:0]                  total_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        jca_pkg::REG_WIDTH_0:  width_r[0]  <= cfg_data;
        jca_pkg::REG_HEIGHT_0: height_r[0] <= cfg_data;
        jca_pkg::REG_WIDTH_1:  width_r[1]  <= cfg_data;
        jca_pkg::REG_HEIGHT_1: height_r[1] <= cfg_data;
        jca_pkg::REG_WIDTH_2:  width_r[2]  <= cfg_data;
        jca_pkg::REG_HEIGHT_2: height_r[2] <= cfg_data;
        jca_pkg::REG_WIDTH_3:  width_r[3]  <= cfg_data;
        jca_pkg::REG_HEIGHT_3: height_r[3] <= cfg_data;
      endcase
    end
  end

  // blocks per component; slots past the component limit count nothing
  always_comb begin
    for (int c = 0; c < jca_pkg::NUM_SLOTS; c++) begin
      if (c < jca_pkg::MAX_COMPONENTS) begin
        cnt_nxt[c] = jca_pkg::CNT_W'(height_r[c]) * jca_pkg::CNT_W'(width_r[c]);
      end else begin
        cnt_nxt[c] = '0;
      end
    end
  end

  always_comb begin
    pair01     = jca_pkg::CUM_W'(cnt_r[0]) + jca_pkg::CUM_W'(cnt_r[1]);
    pair23     = jca_pkg::CUM_W'(cnt_r[2]) + jca_pkg::CUM_W'(cnt_r[3]);
    cum_nxt[0] = jca_pkg::CUM_W'(cnt_r[0]);
    cum_nxt[1] = pair01;
    cum_nxt[2] = pair01 + jca_pkg::CUM_W'(cnt_r[2]);
    cum_nxt[3] = pair01 + pair23;
    total_full = {cum_nxt[3], {jca_pkg::BLOCK_LOG2{1'b0}}};
    if (|total_full[jca_pkg::TOTAL_FULL_W-1:jca_pkg::TOTAL_W]) begin
      total_nxt = jca_pkg::TOTAL_MAX;
    end else begin
      total_nxt = total_full[jca_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      cum_r    <= '0;
      total_r  <= '0;
      settle_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      cum_r    <= cum_nxt;
      total_r  <= total_nxt;
      settle_r <= cfg_valid;
    end
  end

  assign view.cum    = cum_r;
  assign view.width  = width_r;
  assign view.total  = total_r;
  assign view.settle = settle_r;

  // with no configuration write now and settle_r clear now and in its past value, the derived sums stay stable
  a_sums_settled: assert property (@(posedge clk) disable iff (!rst_n)
    !settle_r && !$past(settle_r) && !cfg_valid |=> $stable(cum_r) && $stable(total_r))
    else $error("running sums changed without a configuration write");

endmodule

// File: sv/jca_locate.sv
// input register and component search stage that sets up the row/column divide
`timescale 1ns / 1ps

module jca_locate (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_hold,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [jca_pkg::IDX_W-1:0]      in_flat_index,
  input  jca_pkg::cfg_view_t             view,
  output logic                           out_valid,
  input  logic                           out_ready,
  output jca_pkg::div_item_t             out_item
);

  logic                             v1_r;
  logic [jca_pkg::IDX_W-1:0]        idx_r;
  logic                             v2_r;
  jca_pkg::div_item_t               item_r;
  jca_pkg::div_item_t               item_nxt;
  logic                             ready1;
  logic                             ready2;
  logic [jca_pkg::BLK_W-1:0]        blk;
  logic [jca_pkg::NUM_SLOTS-1:0]    hit;
  logic                             found;
  logic [jca_pkg::CUM_W-1:0]        prev;
  logic [jca_pkg::CUM_W-1:0]        base;
  logic [jca_pkg::CUM_W-1:0]        rel_full;
  logic [jca_pkg::BLK_W-1:0]        rel;

  assign ready2   = !v2_r || out_ready;
  assign ready1   = !v1_r || ready2;
  assign in_ready = ready1 && !in_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= in_valid && !in_hold;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      idx_r <= in_flat_index;
    end
    if (v1_r && ready2) begin
      item_r <= item_nxt;
    end
  end

  // compare in whole blocks: every component boundary is a block boundary
  assign blk = idx_r[jca_pkg::IDX_W-1:jca_pkg::BLOCK_LOG2];

  always_comb begin
    for (int c = 0; c < jca_pkg::NUM_SLOTS; c++) begin
      hit[c] = jca_pkg::CUM_W'(blk) < view.cum[c];
    end
  end

  always_comb begin
    found            = 1'b0;
    prev             = '0;
    base             = '0;
    item_nxt.comp    = '0;
    item_nxt.divisor = '0;
    for (int c = 0; c < jca_pkg::NUM_SLOTS; c++) begin
      if (!found && hit[c]) begin
        found            = 1'b1;
        base             = prev;
        item_nxt.comp    = jca_pkg::COMP_W'(c);
        item_nxt.divisor = view.width[c];
      end
      prev = view.cum[c];
    end
    rel_full     = jca_pkg::CUM_W'(blk) - base;
    rel          = rel_full[jca_pkg::BLK_W-1:0];
    item_nxt.oor = !found;
    item_nxt.pos = idx_r[jca_pkg::BLOCK_LOG2-1:0];
    // high part of the block offset is already below the width
    item_nxt.rem = jca_pkg::REG_W'(rel[jca_pkg::BLK_W-1:jca_pkg::QUO_W]);
    item_nxt.dvd = rel[jca_pkg::QUO_W-1:0];
    item_nxt.quo = '0;
  end

  assign out_valid = v2_r;
  assign out_item  = item_r;

  a_divide_setup: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !item_r.oor |-> item_r.rem < item_r.divisor)
    else $error("divide started with partial remainder not below width");

endmodule

// File: sv/jca_div_stage.sv
// one pipeline stage of the restoring divide of block offset by component width
`timescale 1ns / 1ps

module jca_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jca_pkg::div_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output jca_pkg::div_item_t  out_item
);

  logic                        v_r;
  jca_pkg::div_item_t          item_r;
  jca_pkg::div_item_t          item_nxt;
  logic [jca_pkg::REG_W:0]     r2;
  logic [jca_pkg::REG_W:0]     diff;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    item_nxt = in_item;
    r2       = '0;
    diff     = '0;
    for (int j = 0; j < jca_pkg::STEPS_PER_STAGE; j++) begin
      r2           = {item_nxt.rem, item_nxt.dvd[jca_pkg::QUO_W-1]};
      item_nxt.dvd = {item_nxt.dvd[jca_pkg::QUO_W-2:0], 1'b0};
      diff         = r2 - {1'b0, item_nxt.divisor};
      if (r2 >= {1'b0, item_nxt.divisor}) begin
        item_nxt.rem = diff[jca_pkg::REG_W-1:0];
        item_nxt.quo = {item_nxt.quo[jca_pkg::QUO_W-2:0], 1'b1};
      end else begin
        item_nxt.rem = r2[jca_pkg::REG_W-1:0];
        item_nxt.quo = {item_nxt.quo[jca_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_item  = item_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !item_r.oor |-> item_r.rem < item_r.divisor)
    else $error("partial remainder reached the divisor");

endmodule

// File: sv/jpeg_coefficient_address_map_top.sv
// coefficient address map: flat index to component, block row/column and position
// pipeline: input reg, search, then 7 divide stages to the result transaction
// throughput: one transaction per cycle unless stalled; 2 quotient bits per stage
// a config write or its settle flag blocks input while block sums settle
// reset (rst_n, synchronous, active low) clears config registers and all valid bits
`timescale 1ns / 1ps

module jpeg_coefficient_address_map_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jca_pkg::REG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [jca_pkg::IDX_W-1:0]         in_flat_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [jca_pkg::COMP_W-1:0]        out_component,
  output logic [jca_pkg::ROW_W-1:0]         out_block_row,
  output logic [jca_pkg::COL_W-1:0]         out_block_col,
  output logic [jca_pkg::POS_W-1:0]         out_coef_pos,
  output logic                              out_out_of_range,
  output logic [jca_pkg::TOTAL_W-1:0]       out_total_coefficients
);

  jca_pkg::cfg_view_t                 cfg_view;
  logic                               cfg_hold;
  logic [jca_pkg::DIV_STAGES:0]       dv;
  logic [jca_pkg::DIV_STAGES:0]       dr;
  jca_pkg::div_item_t                 ditem [jca_pkg::DIV_STAGES+1];
  jca_pkg::div_item_t                 last;

  assign cfg_ready = 1'b1;
  assign cfg_hold  = cfg_valid || cfg_view.settle;

  jca_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (cfg_view)
  );

  jca_locate u_locate (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_hold       (cfg_hold),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_flat_index (in_flat_index),
    .view          (cfg_view),
    .out_valid     (dv[0]),
    .out_ready     (dr[0]),
    .out_item      (ditem[0])
  );

  for (genvar s = 0; s < jca_pkg::DIV_STAGES; s++) begin : g_div
    jca_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv[s]),
      .in_ready  (dr[s]),
      .in_item   (ditem[s]),
      .out_valid (dv[s+1]),
      .out_ready (dr[s+1]),
      .out_item  (ditem[s+1])
    );
  end

  assign last                   = ditem[jca_pkg::DIV_STAGES];
  assign dr[jca_pkg::DIV_STAGES] = out_ready;
  assign out_valid              = dv[jca_pkg::DIV_STAGES];

  // out-of-range results report zeros for the location fields
  assign out_component          = last.oor ? '0 : last.comp;
  assign out_block_row          = last.oor ? '0 : last.quo[jca_pkg::ROW_W-1:0];
  assign out_block_col          = last.oor ? '0 : last.rem[jca_pkg::COL_W-1:0];
  assign out_coef_pos           = last.oor ? '0 : last.pos;
  assign out_out_of_range       = last.oor;
  assign out_total_coefficients = cfg_view.total;

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input accepted before block sums settled");

endmodule
